// File: design/surplus_charge_controller_macros.svh
// ----------------------------------------------------------------------------
// surplus charge controller assertion macros
// concurrent checks on the clock and reset of the including module
// ----------------------------------------------------------------------------
`ifndef SURPLUS_CHARGE_CONTROLLER_MACROS_SVH
`define SURPLUS_CHARGE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every edge outside reset
`define SCC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SCC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SCC_ASSERT(name, prop, msg)
`define SCC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: design/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// shared widths, register map, reset values and opcodes of the charge controller
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int DEF_TIME_BITS  = 32;
   localparam int DEF_POWER_BITS = 16;

   localparam int SOC_BITS       = 10;
   localparam int PTHR_BITS      = 16;
   localparam int DUR_BITS       = 32;
   localparam int TOLF_BITS      = 16;
   localparam int TOL_BITS       = TOLF_BITS + SOC_BITS;
   localparam int OPCODE_BITS    = 2;
   localparam int PHASE_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOC_THRESHOLD    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONDITION_TIME   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_CHARGE_TIME  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE_FACTOR = 3'd4;

   // reset values
   localparam logic [SOC_BITS-1:0]  RST_SOC_THRESHOLD    = 10'd800;
   localparam logic [PTHR_BITS-1:0] RST_POWER_THRESHOLD  = 16'd0;
   localparam logic [DUR_BITS-1:0]  RST_CONDITION_TIME   = 32'd60000;
   localparam logic [DUR_BITS-1:0]  RST_MIN_CHARGE_TIME  = 32'd600000;
   localparam logic [TOLF_BITS-1:0] RST_TOLERANCE_FACTOR = 16'd256;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_SAMPLE = 2'd0,
      OP_FORCE  = 2'd1,
      OP_STOP   = 2'd2
   } opcode_type;

endpackage

// File: design/surplus_charge_controller.sv
// ----------------------------------------------------------------------------
// surplus_charge_controller
// five-phase charger relay controller driven by timestamped samples and commands
// ----------------------------------------------------------------------------
// Takes one item per clock while the result is not stalled and returns one
// result per item. The item is held in the input register, and a single pass
// through the phase logic loads the result register. That pass holds one
// 16x10 tolerance multiply, two wrapping timer subtract-and-compares and the
// threshold compares. Each item sees the phase and timers left by the item
// before it. Configuration takes effect for items that pass the phase logic
// after the write; csr_ready is always high.
`include "surplus_charge_controller_macros.svh"

module surplus_charge_controller
   import scc_pkg::*;
#(
   parameter int TIME_BITS  = DEF_TIME_BITS,
   parameter int POWER_BITS = DEF_POWER_BITS
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OPCODE_BITS-1:0]       req_opcode,
   input  logic [TIME_BITS-1:0]         req_time_now,
   input  logic signed [POWER_BITS-1:0] req_grid_power,
   input  logic [SOC_BITS-1:0]          req_battery_soc,
   input  logic [DUR_BITS-1:0]          req_force_duration,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_relay_on,
   output logic                         rsp_relay_write,
   output logic [PHASE_BITS-1:0]        rsp_charge_phase,
   output logic                         rsp_forced_mode,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CMP_T_BITS = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;
   localparam int SCALED_BITS = POWER_BITS + 8;
   localparam int CMP_P_BITS = ((SCALED_BITS > TOL_BITS) ? SCALED_BITS : TOL_BITS) + 1;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE   = 3'd0,
      PH_PRE    = 3'd1,
      PH_MIN    = 3'd2,
      PH_ACTIVE = 3'd3,
      PH_POST   = 3'd4
   } phase_type;

   // wrapping elapsed time against a length
   function automatic logic timer_done(input logic [TIME_BITS-1:0] now,
                                       input logic [TIME_BITS-1:0] start,
                                       input logic [DUR_BITS-1:0]  len);
      logic [TIME_BITS-1:0] diff;
      diff = now - start;
      return CMP_T_BITS'(diff) >= CMP_T_BITS'(len);
   endfunction

   // configuration registers
   logic [SOC_BITS-1:0]          soc_threshold_ff;
   logic signed [POWER_BITS-1:0] power_threshold_ff;
   logic [DUR_BITS-1:0]          condition_time_ff;
   logic [DUR_BITS-1:0]          min_charge_time_ff;
   logic [TOLF_BITS-1:0]         tolerance_factor_ff;

   // input stage
   logic                         in_valid_ff;
   logic [OPCODE_BITS-1:0]       in_opcode_ff;
   logic [TIME_BITS-1:0]         in_time_ff;
   logic signed [POWER_BITS-1:0] in_power_ff;
   logic [SOC_BITS-1:0]          in_soc_ff;
   logic [DUR_BITS-1:0]          in_duration_ff;

   // controller state and next values
   phase_type                    phase_ff, phase_in;
   logic                         forced_ff, forced_in;
   logic                         relay_ff, relay_in;
   logic [TIME_BITS-1:0]         cond_start_ff, cond_start_in;
   logic [TIME_BITS-1:0]         min_start_ff, min_start_in;
   logic [DUR_BITS-1:0]          min_length_ff, min_length_in;
   logic                         wrote_in;

   // result register
   logic                         out_valid_ff;
   logic                         out_relay_ff;
   logic                         out_write_ff;
   phase_type                    out_phase_ff;
   logic                         out_forced_ff;

   logic                         advance;
   logic [TOL_BITS-1:0]          tol_prod;
   logic signed [CMP_P_BITS-1:0] pw_scaled;
   logic signed [CMP_P_BITS-1:0] tol_cmp;
   logic                         pw_low;
   logic                         pw_positive;
   logic                         soc_high;
   logic                         over_tol;
   logic                         under_tol;
   logic                         cond_done;
   logic                         min_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         soc_threshold_ff    <= RST_SOC_THRESHOLD;
         power_threshold_ff  <= POWER_BITS'(RST_POWER_THRESHOLD);
         condition_time_ff   <= RST_CONDITION_TIME;
         min_charge_time_ff  <= RST_MIN_CHARGE_TIME;
         tolerance_factor_ff <= RST_TOLERANCE_FACTOR;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SOC_THRESHOLD: begin
               soc_threshold_ff <= csr_wdata[SOC_BITS-1:0];
            end
            CSR_POWER_THRESHOLD: begin
               // 16-bit value, then seen at the power width
               power_threshold_ff <= POWER_BITS'(csr_wdata[PTHR_BITS-1:0]);
            end
            CSR_CONDITION_TIME: begin
               condition_time_ff <= csr_wdata[DUR_BITS-1:0];
            end
            CSR_MIN_CHARGE_TIME: begin
               min_charge_time_ff <= csr_wdata[DUR_BITS-1:0];
            end
            CSR_TOLERANCE_FACTOR: begin
               tolerance_factor_ff <= csr_wdata[TOLF_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_opcode_ff   <= req_opcode;
         in_time_ff     <= req_time_now;
         in_power_ff    <= req_grid_power;
         in_soc_ff      <= req_battery_soc;
         in_duration_ff <= req_force_duration;
      end
   end

   // compares
   assign tol_prod    = TOL_BITS'(tolerance_factor_ff) * TOL_BITS'(in_soc_ff);
   assign pw_scaled   = {{(CMP_P_BITS - SCALED_BITS){in_power_ff[POWER_BITS-1]}},
                         in_power_ff, 8'd0};
   assign tol_cmp     = $signed({{(CMP_P_BITS - TOL_BITS){1'b0}}, tol_prod});
   assign over_tol    = pw_scaled > tol_cmp;
   assign under_tol   = pw_scaled < tol_cmp;
   assign pw_low      = in_power_ff < power_threshold_ff;
   assign pw_positive = !in_power_ff[POWER_BITS-1] && (in_power_ff != '0);
   assign soc_high    = in_soc_ff > soc_threshold_ff;
   assign cond_done   = timer_done(in_time_ff, cond_start_ff, condition_time_ff);
   assign min_done    = timer_done(in_time_ff, min_start_ff, min_length_ff);

   always_comb begin
      phase_in      = phase_ff;
      forced_in     = forced_ff;
      relay_in      = relay_ff;
      cond_start_in = cond_start_ff;
      min_start_in  = min_start_ff;
      min_length_in = min_length_ff;
      wrote_in      = 1'b0;
      if (in_opcode_ff == OP_FORCE) begin
         relay_in      = 1'b1;
         wrote_in      = 1'b1;
         forced_in     = 1'b1;
         min_start_in  = in_time_ff;
         min_length_in = in_duration_ff;
         phase_in      = PH_MIN;
      end else if (in_opcode_ff == OP_STOP) begin
         relay_in  = 1'b0;
         wrote_in  = 1'b1;
         forced_in = 1'b0;
         phase_in  = PH_IDLE;
      end else if (in_opcode_ff == OP_SAMPLE) begin
         case (phase_ff)
            PH_IDLE: begin
               if (soc_high && pw_low) begin
                  cond_start_in = in_time_ff;
                  phase_in      = PH_PRE;
               end
            end
            PH_PRE: begin
               if (!pw_low) begin
                  phase_in = PH_IDLE;
               end else if (cond_done) begin
                  relay_in      = 1'b1;
                  wrote_in      = 1'b1;
                  forced_in     = 1'b0;
                  min_start_in  = in_time_ff;
                  min_length_in = min_charge_time_ff;
                  phase_in      = PH_MIN;
               end
            end
            PH_MIN: begin
               if (min_done) begin
                  // forced run ending while importing stops right away
                  if (forced_ff && pw_positive) begin
                     relay_in = 1'b0;
                     wrote_in = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_ACTIVE;
                  end
                  forced_in = 1'b0;
               end
            end
            PH_ACTIVE: begin
               if (over_tol) begin
                  cond_start_in = in_time_ff;
                  phase_in      = PH_POST;
               end
            end
            PH_POST: begin
               if (under_tol) begin
                  phase_in = PH_ACTIVE;
               end else if (cond_done) begin
                  relay_in  = 1'b0;
                  wrote_in  = 1'b1;
                  forced_in = 1'b0;
                  phase_in  = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         forced_ff     <= 1'b0;
         relay_ff      <= 1'b0;
         cond_start_ff <= '0;
         min_start_ff  <= '0;
         min_length_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff      <= phase_in;
            forced_ff     <= forced_in;
            relay_ff      <= relay_in;
            cond_start_ff <= cond_start_in;
            min_start_ff  <= min_start_in;
            min_length_ff <= min_length_in;
            out_valid_ff  <= 1'b1;
            out_relay_ff  <= relay_in;
            out_write_ff  <= wrote_in;
            out_phase_ff  <= phase_in;
            out_forced_ff <= forced_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_relay_on     = out_relay_ff;
   assign rsp_relay_write  = out_write_ff;
   assign rsp_charge_phase = out_phase_ff;
   assign rsp_forced_mode  = out_forced_ff;

   `SCC_ASSERT(a_relay_tracks_phase,
      !out_valid_ff || (out_relay_ff == ((out_phase_ff == PH_MIN) ||
         (out_phase_ff == PH_ACTIVE) || (out_phase_ff == PH_POST))),
      "relay level disagrees with charge phase")
   `SCC_ASSERT(a_forced_only_in_min,
      !out_valid_ff || !out_forced_ff || (out_phase_ff == PH_MIN),
      "forced mode outside minimum phase")
   `SCC_ASSERT_NEXT(a_advance_gives_result, advance,
      out_valid_ff && (out_phase_ff == phase_ff),
      "item left input stage without a result")

endmodule
